/* rtl/qvr_pkg.sv */
// Shared types and constants for the quaternion vector rotation core.
// Used by every module under rtl/ but qvr_checker; depends on nothing else.
package qvr_pkg;

  // Field widths and fixed-point scale.
  localparam int QW   = 16;          // quaternion component, Q1.15
  localparam int VW   = 24;          // vector component
  localparam int FRAC = 15;          // fraction bits of the quaternion

  // Internal widths of the two Hamilton products.
  localparam int M1W = QW + VW;      // one product of q (x) v
  localparam int PW  = M1W + 2;      // sum of three such products
  localparam int M2W = PW + QW;      // one product of p (x) q*
  localparam int SW  = M2W + 2;      // sum of four such products

  // Rounding shift back to the vector's format.
  localparam int RSH = 2 * FRAC;

  typedef struct packed {
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [VW-1:0] z;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] x;
  } vec_t;

  // Full quaternion p = q (x) v, kept exact at scale 2^15.
  typedef struct packed {
    logic signed [PW-1:0] p3;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p0;
  } pquat_t;

  // Vector part of p (x) q*, kept exact at scale 2^30.
  typedef struct packed {
    logic signed [SW-1:0] z;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] x;
  } rsum_t;

endpackage

/* rtl/qvr_fwd_prod.sv */
// First Hamilton product p = q (x) (0, v): a multiply stage and a sum stage.
// Depends on qvr_pkg.
module qvr_fwd_prod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qvr_pkg::quat_t quat_i,
  input  qvr_pkg::vec_t  vec_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qvr_pkg::quat_t quat_o,
  output qvr_pkg::pquat_t pq_o
);
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [M1W-1:0] xvx, yvy, zvz;
    logic signed [M1W-1:0] wvx, yvz, zvy;
    logic signed [M1W-1:0] wvy, zvx, xvz;
    logic signed [M1W-1:0] wvz, xvy, yvx;
  } fwd_prod_t;

  fwd_prod_t prod_d, prod_q;
  quat_t     quat_a_q, quat_b_q;
  pquat_t    pq_d, pq_q;
  logic      valid_a_q, valid_b_q;
  logic      ready_a, ready_b;

  // A stage takes a new beat when it is empty or its content moves on.
  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_comb begin
    prod_d.xvx = quat_i.x * vec_i.x;
    prod_d.yvy = quat_i.y * vec_i.y;
    prod_d.zvz = quat_i.z * vec_i.z;
    prod_d.wvx = quat_i.w * vec_i.x;
    prod_d.yvz = quat_i.y * vec_i.z;
    prod_d.zvy = quat_i.z * vec_i.y;
    prod_d.wvy = quat_i.w * vec_i.y;
    prod_d.zvx = quat_i.z * vec_i.x;
    prod_d.xvz = quat_i.x * vec_i.z;
    prod_d.wvz = quat_i.w * vec_i.z;
    prod_d.xvy = quat_i.x * vec_i.y;
    prod_d.yvx = quat_i.y * vec_i.x;
  end

  always_comb begin
    pq_d.p0 = -PW'(prod_q.xvx) - PW'(prod_q.yvy) - PW'(prod_q.zvz);
    pq_d.p1 =  PW'(prod_q.wvx) + PW'(prod_q.yvz) - PW'(prod_q.zvy);
    pq_d.p2 =  PW'(prod_q.wvy) + PW'(prod_q.zvx) - PW'(prod_q.xvz);
    pq_d.p3 =  PW'(prod_q.wvz) + PW'(prod_q.xvy) - PW'(prod_q.yvx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      prod_q   <= prod_d;
      quat_a_q <= quat_i;
    end
    if (ready_b && valid_a_q) begin
      pq_q     <= pq_d;
      quat_b_q <= quat_a_q;
    end
  end

  assign out_valid_o = valid_b_q;
  assign quat_o      = quat_b_q;
  assign pq_o        = pq_q;

endmodule

/* rtl/qvr_conj_prod.sv */
// Second Hamilton product p (x) q*, vector part only: multiply and sum stages.
// Depends on qvr_pkg.
module qvr_conj_prod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qvr_pkg::quat_t  quat_i,
  input  qvr_pkg::pquat_t pq_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output qvr_pkg::rsum_t  sum_o
);
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [M2W-1:0] p0x, p0y, p0z;
    logic signed [M2W-1:0] p1w, p1y, p1z;
    logic signed [M2W-1:0] p2w, p2x, p2z;
    logic signed [M2W-1:0] p3w, p3x, p3y;
  } conj_prod_t;

  conj_prod_t prod_d, prod_q;
  rsum_t      sum_d, sum_q;
  logic       valid_c_q, valid_d_q;
  logic       ready_c, ready_d;

  assign ready_d    = !valid_d_q || out_ready_i;
  assign ready_c    = !valid_c_q || ready_d;
  assign in_ready_o = ready_c;

  always_comb begin
    prod_d.p0x = pq_i.p0 * quat_i.x;
    prod_d.p0y = pq_i.p0 * quat_i.y;
    prod_d.p0z = pq_i.p0 * quat_i.z;
    prod_d.p1w = pq_i.p1 * quat_i.w;
    prod_d.p1y = pq_i.p1 * quat_i.y;
    prod_d.p1z = pq_i.p1 * quat_i.z;
    prod_d.p2w = pq_i.p2 * quat_i.w;
    prod_d.p2x = pq_i.p2 * quat_i.x;
    prod_d.p2z = pq_i.p2 * quat_i.z;
    prod_d.p3w = pq_i.p3 * quat_i.w;
    prod_d.p3x = pq_i.p3 * quat_i.x;
    prod_d.p3y = pq_i.p3 * quat_i.y;
  end

  // The conjugate negates x, y and z of q; the signs are folded in here.
  always_comb begin
    sum_d.x = -SW'(prod_q.p0x) + SW'(prod_q.p1w) - SW'(prod_q.p2z) + SW'(prod_q.p3y);
    sum_d.y = -SW'(prod_q.p0y) + SW'(prod_q.p2w) - SW'(prod_q.p3x) + SW'(prod_q.p1z);
    sum_d.z = -SW'(prod_q.p0z) + SW'(prod_q.p3w) - SW'(prod_q.p1y) + SW'(prod_q.p2x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      if (ready_c) begin
        valid_c_q <= in_valid_i;
      end
      if (ready_d) begin
        valid_d_q <= valid_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (ready_d && valid_c_q) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = valid_d_q;
  assign sum_o       = sum_q;

endmodule

/* rtl/qvr_round_sat.sv */
// Rounding to nearest (ties up) and 24-bit saturation into the output register.
// Depends on qvr_pkg.
module qvr_round_sat (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qvr_pkg::rsum_t sum_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qvr_pkg::vec_t  rot_o,
  output logic           clip_o
);
  import qvr_pkg::*;

  // Bits of the rounded value from the sign bit of a 24-bit result upward.
  localparam int TOPW = SW + 1 - RSH - (VW - 1);

  vec_t rot_d, rot_q;
  logic clip_d, clip_q;
  logic valid_q;
  logic clip_x, clip_y, clip_z;

  // Returns the saturated component; the flag goes out through clip.
  function automatic logic signed [VW-1:0] round_sat(input logic signed [SW-1:0] s,
                                                     output logic clip);
    logic signed [SW:0]   t;
    logic [TOPW-1:0]      top;
    logic signed [VW-1:0] res;
    t    = (SW+1)'(s) + ((SW+1)'(1) <<< (RSH - 1));
    top  = t[SW:RSH+VW-1];
    clip = !((top == '0) || (top == '1));
    if (!clip) begin
      res = t[RSH+VW-1:RSH];
    end else if (t[SW]) begin
      res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res = {1'b0, {(VW-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    rot_d.x = round_sat(sum_i.x, clip_x);
    rot_d.y = round_sat(sum_i.y, clip_y);
    rot_d.z = round_sat(sum_i.z, clip_z);
    clip_d  = clip_x || clip_y || clip_z;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rot_o       = rot_q;
  assign clip_o      = clip_q;

endmodule

/* rtl/quaternion_vector_rotation_core.sv */
// Pipeline: five register stages.
// Throughput: one beat per cycle without output stalls, set by the pipelined stages.
// Reset: rst_ni clears every stage's valid bit at once; data registers are not reset.
// Depends on qvr_pkg, qvr_fwd_prod, qvr_conj_prod and qvr_round_sat.
module quaternion_vector_rotation_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input beat: rotation quaternion and the vector to rotate.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z,
  // [87:64] vec_x, [111:88] vec_y, [135:112] vec_z
  input  logic [135:0] s_axis_tdata,
  // Output beat: the rotated vector.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] rot_x, [47:24] rot_y, [71:48] rot_z
  output logic [71:0]  m_axis_tdata,
  // [0] clipped
  output logic [0:0]   m_axis_tuser
);
  import qvr_pkg::*;

  // The core computes r = q (x) (0, v) (x) q* in exact integer arithmetic and
  // returns the vector part of r, rounded to nearest with ties toward plus
  // infinity and saturated to 24 bits. The quaternion is used as given, so a
  // quaternion that is not of unit length scales the vector by |q|^2.
  //
  // The pipeline has five stages, each holding a valid bit:
  //   1. twelve 16x24 products of q and v
  //   2. three-term sums giving the full quaternion p = q (x) v
  //   3. twelve 42x16 products of p and q
  //   4. four-term sums giving the vector part of p (x) q*
  //   5. rounding and saturation into the output register
  // Each stage loads when it is empty or its content moves on, so bubbles
  // are squeezed out and the input side keeps accepting beats while a
  // finished result waits at the output, until every stage is full.

  quat_t  quat_in;
  vec_t   vec_in;
  quat_t  quat_fwd;
  pquat_t pq_fwd;
  rsum_t  sum_conj;
  vec_t   rot_out;
  logic   clip_out;
  logic   fwd_valid, fwd_ready;
  logic   conj_valid, conj_ready;

  assign quat_in.w = s_axis_tdata[15:0];
  assign quat_in.x = s_axis_tdata[31:16];
  assign quat_in.y = s_axis_tdata[47:32];
  assign quat_in.z = s_axis_tdata[63:48];
  assign vec_in.x  = s_axis_tdata[87:64];
  assign vec_in.y  = s_axis_tdata[111:88];
  assign vec_in.z  = s_axis_tdata[135:112];

  qvr_fwd_prod u_fwd_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .quat_i      (quat_in),
    .vec_i       (vec_in),
    .out_valid_o (fwd_valid),
    .out_ready_i (fwd_ready),
    .quat_o      (quat_fwd),
    .pq_o        (pq_fwd)
  );

  qvr_conj_prod u_conj_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fwd_valid),
    .in_ready_o  (fwd_ready),
    .quat_i      (quat_fwd),
    .pq_i        (pq_fwd),
    .out_valid_o (conj_valid),
    .out_ready_i (conj_ready),
    .sum_o       (sum_conj)
  );

  qvr_round_sat u_round_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (conj_valid),
    .in_ready_o  (conj_ready),
    .sum_i       (sum_conj),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rot_o       (rot_out),
    .clip_o      (clip_out)
  );

  assign m_axis_tdata = {rot_out.z, rot_out.y, rot_out.x};
  assign m_axis_tuser = clip_out;

endmodule

/* rtl/qvr_checker.sv */
// Port-level checks for the quaternion vector rotation core, bound to the top level.
// Depends only on the top level's ports.
module qvr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  logic in_beat;
  logic at_limit_x, at_limit_y, at_limit_z;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign at_limit_x = (m_axis_tdata[23:0] == 24'h7fffff) || (m_axis_tdata[23:0] == 24'h800000);
  assign at_limit_y = (m_axis_tdata[47:24] == 24'h7fffff) ||
                      (m_axis_tdata[47:24] == 24'h800000);
  assign at_limit_z = (m_axis_tdata[71:48] == 24'h7fffff) ||
                      (m_axis_tdata[71:48] == 24'h800000);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // The clip flag is only set when some component sits at a saturation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> at_limit_x || at_limit_y || at_limit_z)
    else $error("clip flag set without a saturated component");

  // With the output side ready all along, a beat comes out after five stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_beat, 5) && $past(rst_ni, 5) && $past(rst_ni, 4) && $past(rst_ni, 3) &&
    $past(rst_ni, 2) && $past(rst_ni, 1) && $past(m_axis_tready, 4) &&
    $past(m_axis_tready, 3) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1)
      |-> m_axis_tvalid)
    else $error("result missing after pipeline latency");

  // While the output stage is empty the input side must not stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the pipeline has room");

endmodule

bind quaternion_vector_rotation_core qvr_checker u_qvr_checker (.*);
